### sv/rms_normalizer_with_clamp_defines.svh
// Assertion helpers used by rnc_ctrl.
`ifndef RMS_NORMALIZER_WITH_CLAMP_DEFINES_SVH
`define RMS_NORMALIZER_WITH_CLAMP_DEFINES_SVH

// Checked on every rising clk edge outside reset.
`define RNC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define RNC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rnc_pkg.sv
package rnc_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int SUM_W = 37;
	localparam int DVS_W = 19;
	localparam int ROOT_W = 16;
	localparam int X_W = 32;
	localparam logic [X_W-1:0] SINE_MS = 32'd2097152;

	typedef enum logic [1:0] {
		REG_GAIN = 2'd0,
		REG_RAIL = 2'd1,
		REG_EPS  = 2'd2
	} rnc_reg_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_READ,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT
	} rnc_state_t;

	typedef struct packed {
		logic ld;
		logic mean_go;
		logic root_go;
		logic rd;
		logic mul;
		logic scl_go;
		logic emit;
	} rnc_cmd_t;

	typedef struct packed {
		logic blk_end;
		logic div_done;
		logic sqrt_done;
		logic out_free;
		logic last_k;
	} rnc_stat_t;

	localparam logic signed [15:0] SINE_ROM [64] = '{
		16'sd0, 16'sd204, 16'sd407, 16'sd605, 16'sd798, 16'sd982, 16'sd1156, 16'sd1319,
		16'sd1469, 16'sd1604, 16'sd1723, 16'sd1825, 16'sd1909, 16'sd1973, 16'sd2018,
		16'sd2043, 16'sd2047, 16'sd2031, 16'sd1994, 16'sd1938, 16'sd1862, 16'sd1768,
		16'sd1656, 16'sd1527, 16'sd1383, 16'sd1226, 16'sd1056, 16'sd875, 16'sd686,
		16'sd490, 16'sd289, 16'sd85, -16'sd120, -16'sd323, -16'sd523, -16'sd718,
		-16'sd906, -16'sd1085, -16'sd1253, -16'sd1409, -16'sd1550, -16'sd1676,
		-16'sd1785, -16'sd1876, -16'sd1949, -16'sd2002, -16'sd2035, -16'sd2048,
		-16'sd2040, -16'sd2012, -16'sd1964, -16'sd1896, -16'sd1809, -16'sd1704,
		-16'sd1583, -16'sd1445, -16'sd1293, -16'sd1128, -16'sd952, -16'sd766,
		-16'sd572, -16'sd373, -16'sd170, 16'sd34
	};

endpackage

### sv/rnc_ifs.sv
interface rnc_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] sample_in;
	logic last_sample;
	modport source(output valid, sample_in, last_sample, input ready);
	modport sink(input valid, sample_in, last_sample, output ready);
endinterface

interface rnc_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] sample_out;
	logic [15:0] rms_value;
	logic flatline_seen;
	logic [15:0] flatline_total;
	logic last_result;
	modport source(output valid, sample_out, rms_value, flatline_seen, flatline_total,
		last_result, input ready);
	modport sink(input valid, sample_out, rms_value, flatline_seen, flatline_total,
		last_result, output ready);
endinterface

### sv/rnc_div.sv
module rnc_div #(
	parameter int DW = 37,
	parameter int VW = 19
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quo
);
	localparam int CNT_W = $clog2(DW);

	logic          busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] dvs_q;
	logic [VW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits = trial >= {1'b0, dvs_q};
	assign done = busy_q && (cnt_q == CNT_W'(DW - 1));
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) busy_q <= 1'b0;
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? VW'(trial - {1'b0, dvs_q}) : VW'(trial);
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end
endmodule

### sv/rnc_dp.sv
module rnc_dp #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rnc_pkg::rnc_cmd_t cmd,
	output rnc_pkg::rnc_stat_t st,
	input  logic signed [15:0] sample_in,
	input  logic              last_sample,
	input  logic [15:0]       gain_q15,
	input  logic [14:0]       rail_limit,
	input  logic [15:0]       noise_floor,
	rnc_out_if.source         res
);
	import rnc_pkg::*;

	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);

	logic signed [15:0] store_q [MAX_SAMPLES];
	logic signed [15:0] rd_q;
	logic [CW-1:0]  fill_q;
	logic [CW-1:0]  k_q;
	logic [SUM_W-1:0] sum_q;
	logic [15:0]    flat_cnt_q;
	logic           flat_q;
	logic [ROOT_W-1:0] root_q;
	logic [X_W-1:0] x_q;
	logic [3:0]     bit_q;
	logic           sq_busy_q;
	logic [31:0]    p_q;
	logic           neg_q;

	logic [15:0]    mag_in;
	logic [SUM_W-1:0] div_a;
	logic [DVS_W-1:0] div_b;
	logic           div_done;
	logic [SUM_W-1:0] div_quo;
	logic           flat;
	logic [X_W-1:0] mean_eff;
	logic [ROOT_W-1:0] trial;
	logic signed [15:0] v;
	logic [15:0]    mag_v;
	logic [14:0]    qc;

	assign mag_in = sample_in[15] ? 16'(~sample_in + 1'b1) : 16'(sample_in);

	assign div_a = cmd.mean_go ? sum_q : SUM_W'(p_q);
	assign div_b = cmd.mean_go ? DVS_W'(fill_q) : {root_q, 3'b000};

	rnc_div #(.DW(SUM_W), .VW(DVS_W)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.mean_go | cmd.scl_go),
		.dividend(div_a),
		.divisor(div_b),
		.done(div_done),
		.quo(div_quo)
	);

	assign flat = div_quo < SUM_W'(noise_floor);
	assign mean_eff = flat ? SINE_MS : X_W'(div_quo);
	assign trial = root_q | (ROOT_W'(1) << bit_q);

	assign v = flat_q ? SINE_ROM[6'(k_q)] : rd_q;
	assign mag_v = v[15] ? 16'(~v + 1'b1) : 16'(v);

	always_comb begin
		if (root_q == '0) qc = (p_q != '0) ? rail_limit : '0;
		else if (div_quo > SUM_W'(rail_limit)) qc = rail_limit;
		else qc = div_quo[14:0];
	end

	assign st.blk_end = last_sample || (fill_q == CW'(MAX_SAMPLES - 1));
	assign st.div_done = div_done;
	assign st.sqrt_done = sq_busy_q && (bit_q == 4'd0);
	assign st.out_free = !res.valid || res.ready;
	assign st.last_k = (CW'(k_q + 1'b1) == fill_q);

	always_ff @(posedge clk) begin
		if (cmd.ld) store_q[fill_q[AW-1:0]] <= sample_in;
		if (cmd.rd) rd_q <= store_q[k_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			k_q <= '0;
			sum_q <= '0;
			flat_cnt_q <= '0;
			flat_q <= 1'b0;
			sq_busy_q <= 1'b0;
			res.valid <= 1'b0;
		end else begin
			if (cmd.ld) begin
				fill_q <= fill_q + 1'b1;
				sum_q <= sum_q + SUM_W'(32'(mag_in) * 32'(mag_in));
			end
			if (cmd.root_go) begin
				flat_q <= flat;
				if (flat && flat_cnt_q != 16'hFFFF) flat_cnt_q <= flat_cnt_q + 1'b1;
				sq_busy_q <= 1'b1;
			end else if (st.sqrt_done) begin
				sq_busy_q <= 1'b0;
			end
			if (cmd.emit) begin
				res.valid <= 1'b1;
				if (st.last_k) begin
					fill_q <= '0;
					sum_q <= '0;
					k_q <= '0;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end else if (res.ready) begin
				res.valid <= 1'b0;
			end
		end
	end

	// square root one bit per cycle, high bit first
	always_ff @(posedge clk) begin
		if (cmd.root_go) begin
			x_q <= mean_eff + X_W'(noise_floor);
			root_q <= '0;
			bit_q <= 4'd15;
		end else if (sq_busy_q) begin
			if (32'(trial) * 32'(trial) <= x_q) root_q <= trial;
			bit_q <= bit_q - 1'b1;
		end
		if (cmd.mul) begin
			p_q <= 32'(mag_v) * 32'(gain_q15);
			neg_q <= v[15];
		end
		if (cmd.emit) begin
			res.sample_out <= neg_q ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
			res.rms_value <= root_q;
			res.flatline_seen <= flat_q;
			res.flatline_total <= flat_cnt_q;
			res.last_result <= st.last_k;
		end
	end
endmodule

### sv/rnc_ctrl.sv
module rnc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rnc_pkg::rnc_stat_t st,
	output rnc_pkg::rnc_cmd_t  cmd
);
	import rnc_pkg::*;
	`include "rms_normalizer_with_clamp_defines.svh"

	rnc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.ld = in_valid;
				if (in_valid && st.blk_end) state_d = ST_MEAN_GO;
			end
			ST_MEAN_GO: begin
				cmd.mean_go = 1'b1;
				state_d = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: if (st.div_done) state_d = ST_ROOT_GO;
			ST_ROOT_GO: begin
				cmd.root_go = 1'b1;
				state_d = ST_ROOT_WAIT;
			end
			ST_ROOT_WAIT: if (st.sqrt_done) state_d = ST_READ;
			ST_READ: begin
				cmd.rd = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				cmd.scl_go = 1'b1;
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: if (st.div_done) state_d = ST_EMIT;
			ST_EMIT: begin
				// hold until the output register can take the transaction
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d = st.last_k ? ST_LOAD : ST_READ;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	`RNC_ASSERT(a_cmd_excl, $onehot0(cmd), "controller issued two commands at once")
	`RNC_ASSERT(a_emit_free, cmd.emit |-> st.out_free, "emit while output register busy")
	`RNC_ASSERT(a_blk_mean, (in_ready && in_valid && st.blk_end) |=> cmd.mean_go,
		"block end did not start mean division")
endmodule

### sv/rms_normalizer_with_clamp.sv
// RMS normalizer with flatline substitution and rail clamp. Samples (signed
// Q3.12) are taken one per cycle into a block store until one is marked last
// or MAX_SAMPLES have arrived. The block is then processed: the mean square
// comes from a one-bit-per-cycle divider, the root from a bit-serial square
// root, and each sample is scaled by gain/(8*rms) through the same divider,
// each result passing through store read, multiply, 37-step divide and
// output load. The next block is accepted only after the last result of a
// block is loaded into the output register, which waits while the result
// side holds ready low. Blocks whose mean square falls below the noise floor
// are replaced by a 0.5 amplitude sine and counted in a saturating flatline
// counter. Write gain_q15 (index 0), rail_limit (1) and the noise floor (2)
// only while the block is idle.
module rms_normalizer_with_clamp #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	rnc_in_if.sink      sample_ch,
	rnc_out_if.source   result_ch
);
	import rnc_pkg::*;

	logic [15:0] gain_q;
	logic [14:0] rail_q;
	logic [15:0] eps_q;
	rnc_cmd_t  cmd;
	rnc_stat_t st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 16'd28672;
			rail_q <= 15'd8192;
			eps_q <= 16'd17;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_GAIN: gain_q <= cfg_data;
				REG_RAIL: rail_q <= cfg_data[14:0];
				REG_EPS:  eps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rnc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(sample_ch.valid),
		.in_ready(sample_ch.ready),
		.st(st),
		.cmd(cmd)
	);

	rnc_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.st(st),
		.sample_in(sample_ch.sample_in),
		.last_sample(sample_ch.last_sample),
		.gain_q15(gain_q),
		.rail_limit(rail_q),
		.noise_floor(eps_q),
		.res(result_ch)
	);
endmodule

### dv/rms_normalizer_with_clamp_test.sv
module rms_normalizer_with_clamp_test;
	import rnc_pkg::*;

	localparam int BLOCK_MAX = 64;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic signed [15:0] smp;
		logic [15:0]        rms;
		logic               flat;
		logic [15:0]        total;
		logic               last;
	} norm_result_t;

	class norm_scoreboard;
		logic [15:0] gain;
		logic [14:0] rail;
		logic [15:0] eps;
		int          block_buf [BLOCK_MAX];
		longint unsigned sq_sum;
		int          fill;
		logic [15:0] flat_cnt;
		norm_result_t pending [$];
		int          errors;

		function new();
			gain = 16'd28672;
			rail = 15'd8192;
			eps = 16'd17;
			sq_sum = 0;
			fill = 0;
			flat_cnt = 0;
			errors = 0;
		endfunction

		function void set_reg(rnc_reg_t idx, logic [15:0] val);
			case (idx)
				REG_GAIN: gain = val;
				REG_RAIL: rail = val[14:0];
				REG_EPS: eps = val;
				default: ;
			endcase
		endfunction

		function longint unsigned int_sqrt(longint unsigned x);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function void note_sample(logic signed [15:0] s, logic last);
			longint unsigned mag, ms, root, p, q;
			longint v;
			bit flat;
			norm_result_t r;
			block_buf[fill] = s;
			mag = (s < 0) ? -longint'(s) : longint'(s);
			sq_sum += mag * mag;
			fill++;
			if (!last && fill < BLOCK_MAX)
				return;
			ms = sq_sum / fill;
			flat = ms < eps;
			if (flat) begin
				if (flat_cnt != 16'hFFFF)
					flat_cnt++;
				ms = 64'd2097152;
			end
			root = int_sqrt(ms + eps);
			for (int k = 0; k < fill; k++) begin
				v = flat ? longint'(SINE_ROM[k]) : longint'(block_buf[k]);
				mag = (v < 0) ? -v : v;
				p = mag * gain;
				if (root == 0)
					q = (p != 0) ? rail : 0;
				else
					q = p / (root * 8);
				if (q > rail)
					q = rail;
				r.smp = (v < 0) ? -q[15:0] : q[15:0];
				r.rms = (root > 64'hFFFF) ? 16'hFFFF : root[15:0];
				r.flat = flat;
				r.total = flat_cnt;
				r.last = (k + 1 == fill);
				pending.push_back(r);
			end
			fill = 0;
			sq_sum = 0;
		endfunction

		function void check_result(norm_result_t got);
			norm_result_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result smp=%0d rms=%0d", $realtime, got.smp,
					got.rms);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.smp !== exp_r.smp) begin
				$display("%0t: sample_out expected %0d actual %0d", $realtime, exp_r.smp,
					got.smp);
				errors++;
			end
			if (got.rms !== exp_r.rms) begin
				$display("%0t: rms_value expected %0d actual %0d", $realtime, exp_r.rms,
					got.rms);
				errors++;
			end
			if (got.flat !== exp_r.flat) begin
				$display("%0t: flatline_seen expected %0b actual %0b", $realtime,
					exp_r.flat, got.flat);
				errors++;
			end
			if (got.total !== exp_r.total) begin
				$display("%0t: flatline_total expected %0d actual %0d", $realtime,
					exp_r.total, got.total);
				errors++;
			end
			if (got.last !== exp_r.last) begin
				$display("%0t: last_result expected %0b actual %0b", $realtime,
					exp_r.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [15:0] cfg_data;
	longint      cycles;
	bit          steady;
	int          sent;

	rnc_in_if  sample_ch();
	rnc_out_if result_ch();

	norm_scoreboard sb;

	rms_normalizer_with_clamp dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.sample_ch(sample_ch),
		.result_ch(result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side: ready changes at the falling edge, transactions are taken at the rising one
	initial begin
		norm_result_t got;
		int stall;
		result_ch.ready = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				result_ch.ready = 1'b0;
				stall--;
			end else begin
				result_ch.ready = 1'b1;
				stall = pick_gap();
			end
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				got.smp = result_ch.sample_out;
				got.rms = result_ch.rms_value;
				got.flat = result_ch.flatline_seen;
				got.total = result_ch.flatline_total;
				got.last = result_ch.last_result;
				sb.check_result(got);
			end
		end
	end

	// call at a falling edge; returns at a falling edge
	task automatic send_sample(logic signed [15:0] s, logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.sample_in = s;
		sample_ch.last_sample = last;
		sample_ch.valid = 1'b1;
		do @(posedge clk); while (!sample_ch.ready);
		sb.note_sample(s, last);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		sample_ch.valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		// the block is already back to loading once its final result has been issued
		repeat (80) @(negedge clk);
	endtask

	task automatic write_reg(rnc_reg_t idx, logic [15:0] val);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic setup(logic [15:0] g, logic [15:0] r, logic [15:0] e);
		drain();
		write_reg(REG_GAIN, g);
		write_reg(REG_RAIL, r);
		write_reg(REG_EPS, e);
	endtask

	function automatic logic signed [15:0] pick_sample(int kind);
		case (kind)
			0: return 16'($urandom);
			1: return $signed(16'($urandom_range(0, 8))) - 16'sd4;
			2: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
			default: return $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
		endcase
	endfunction

	task automatic send_block();
		int len, kind, r;
		bit no_mark;
		r = $urandom_range(0, 99);
		no_mark = 0;
		if (r < 84)
			len = $urandom_range(1, 8);
		else if (r < 96)
			len = $urandom_range(9, 24);
		else begin
			len = BLOCK_MAX;
			no_mark = $urandom_range(0, 1);
		end
		kind = $urandom_range(0, 3);
		for (int i = 0; i < len; i++)
			send_sample(pick_sample(kind), (i == len - 1) && !no_mark);
	endtask

	task automatic random_blocks(int count);
		int target;
		target = sent + count;
		while (sent < target) send_block();
	endtask

	initial begin
		sb = new();
		sent = 0;
		steady = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_GAIN;
		cfg_data = 16'd0;
		sample_ch.valid = 1'b0;
		sample_ch.sample_in = 16'sd0;
		sample_ch.last_sample = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, flatline, single-sample blocks
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sd0, 1'b1);
		send_sample(16'sd1, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd2, 1'b1);
		send_sample(16'sd4096, 1'b0);
		send_sample(-16'sd4096, 1'b0);
		send_sample(16'sd2048, 1'b1);
		send_sample(16'sh5555, 1'b0);
		send_sample(16'shAAAA, 1'b1);
		// zero rms: no bias and silent input
		setup(16'd32768, 16'd32767, 16'd0);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd0, 1'b1);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b1);
		setup(16'd0, 16'd0, 16'd65535);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(-16'sd3, 1'b1);
		send_sample(16'sd100, 1'b1);

		setup(16'd28672, 16'd8192, 16'd17);
		random_blocks(90);
		setup(16'd32768, 16'd32767, 16'd0);
		steady = 1;
		random_blocks(60);
		steady = 0;
		setup(16'd0, 16'd0, 16'd65535);
		random_blocks(50);
		setup(16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32767)),
			16'($urandom_range(0, 65535)));
		random_blocks(90);
		setup(16'd16384, 16'd1, 16'd3000);
		random_blocks(60);
		setup(16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32767)),
			16'($urandom_range(0, 400)));
		random_blocks(80);

		sample_ch.valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
